// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define RVM_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rvm_pkg.sv =====
// shared types and constants of the register machine execute unit
`timescale 1ns / 1ps
package rvm_pkg;

  localparam int unsigned RegCountDef   = 8;
  localparam int unsigned DataStackDef  = 256;
  localparam int unsigned CallStackDef  = 256;
  localparam int unsigned IpW           = 13;
  localparam int unsigned StepW         = 33;
  localparam int unsigned ValW          = 64;
  localparam int unsigned InDataW       = 96;
  localparam int unsigned OutDataW      = 96;
  localparam int unsigned CfgAddrW      = 8;
  localparam int unsigned CfgDataW      = 32;
  localparam logic [31:0] StepLimitRst  = 32'd1000000;
  localparam logic [7:0]  CfgStepLimit  = 8'd0;
  localparam logic [7:0]  CfgProgLength = 8'd1;

  typedef enum logic [4:0] {
    OP_START = 5'd0,  OP_NOP = 5'd1,  OP_RET = 5'd2,  OP_EXIT = 5'd3,
    OP_MOV = 5'd4,    OP_ADD = 5'd5,  OP_SUB = 5'd6,  OP_XOR = 5'd7,
    OP_AND = 5'd8,    OP_OR = 5'd9,   OP_SHL = 5'd10, OP_SHR = 5'd11,
    OP_CMP = 5'd12,   OP_INC = 5'd13, OP_DEC = 5'd14, OP_PUSH = 5'd15,
    OP_POP = 5'd16,   OP_CALL = 5'd17, OP_PRINT_REG = 5'd18,
    OP_PRINT_STR = 5'd19, OP_JMP = 5'd20, OP_JZ = 5'd21, OP_JNZ = 5'd22,
    OP_UNSUPPORTED = 5'd23
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FAULT = 2'd1, ST_UNSUP = 2'd2, ST_STEP = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0, PK_REG = 2'd1, PK_STR = 2'd2
  } pkind_e;

  // listed from the top bit down, so operation lands in the lowest bits
  typedef struct packed {
    logic            malformed;
    logic            target_found;
    logic [11:0]     target_line;
    logic [ValW-1:0] immediate;
    logic [2:0]      src_reg;
    logic            src_is_reg;
    logic [2:0]      dest_reg;
    logic [4:0]      operation;
  } item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IpW-1:0]  next_ip;
    logic            running;
    logic [7:0]      exit_value;
    logic [1:0]      print_kind;
    logic [ValW-1:0] print_value;
    logic            zero_flag;
  } result_t;

  // run control state, stack depths live beside it in the top level
  typedef struct packed {
    logic [IpW-1:0]   ip;
    logic             halted;
    logic [7:0]       exit_val;
    logic [StepW-1:0] steps;
    logic             zero;
  } run_t;

endpackage

// ===== rtl/register_vm_execute_unit_top.sv =====
// top level of the register machine execute unit
//
// one decoded instruction enters on the s_axis channel per transfer and one
// result leaves on the m_axis channel for every instruction, in order
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 step limit, 1 program length); write only while the unit is idle
// latency: an instruction is registered at the input, executed in the next
// cycle and its result registered, so m_axis_tvalid rises one cycle after
// the input transfer
// throughput: one instruction per cycle; the stack memories keep a registered
// read of the top entry, with a one-entry bypass after a push, so
// push, pop, call and ret all run back to back
// reset clears registers, flag, stack depths, pointer, halt, exit code and
// step count and sets the step limit to 1000000 and program length to 0;
// stack memory contents are not cleared
// when the receiver stalls the result register holds and the input register
// fills; s_axis_tready falls only when both are full
`timescale 1ns / 1ps
`include "assert_macros.svh"
module register_vm_execute_unit_top #(
  parameter int unsigned RegCount  = rvm_pkg::RegCountDef,
  parameter int unsigned DataDepth = rvm_pkg::DataStackDef,
  parameter int unsigned CallDepth = rvm_pkg::CallStackDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rvm_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [rvm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operation, dest_reg, src_is_reg, src_reg, immediate, target_line,
  // target_found, malformed, zero fill
  input  logic [rvm_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status, next_ip, running, exit_value, print_kind, print_value,
  // zero_flag, zero fill
  output logic [rvm_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned RegIdxW = $clog2(RegCount);
  localparam int unsigned DsaW    = $clog2(DataDepth);
  localparam int unsigned CsaW    = $clog2(CallDepth);

  rvm_pkg::item_t              item_q;
  logic                        in_valid_q, out_valid_q, fire;
  rvm_pkg::result_t            res_d, res_q;
  rvm_pkg::run_t               run_d, run_q;
  logic [DsaW:0]               dsd_d, dsd_q;
  logic [CsaW:0]               csd_d, csd_q;
  logic [31:0]                 step_limit_q;
  logic [rvm_pkg::IpW-1:0]     prog_len_q;
  logic [rvm_pkg::ValW-1:0]    rf_q [RegCount];
  logic                        rf_we, ds_we, cs_we, ds_we_x, cs_we_x;
  logic [RegIdxW-1:0]          rf_waddr;
  logic [rvm_pkg::ValW-1:0]    rf_wdata, ds_wdata, ds_rdata, ds_top, ds_byp_q;
  logic [rvm_pkg::IpW-1:0]     cs_wdata, cs_rdata, cs_top, cs_byp_q;
  logic                        ds_byp_vq, cs_byp_vq;
  logic [DsaW-1:0]             ds_raddr;
  logic [CsaW-1:0]             cs_raddr;

  // handshake: a new item enters whenever the input register is empty or drains
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.zero_flag, res_q.print_value, res_q.print_kind,
                          res_q.exit_value, res_q.running, res_q.next_ip, res_q.status};

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= rvm_pkg::item_t'(s_axis_tdata[89:0]);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= rvm_pkg::StepLimitRst;
      prog_len_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == rvm_pkg::CfgStepLimit) begin
        step_limit_q <= cfg_wdata_i;
      end else if (cfg_addr_i == rvm_pkg::CfgProgLength) begin
        prog_len_q <= cfg_wdata_i[rvm_pkg::IpW-1:0];
      end
    end
  end

  // top of stack: registered memory read unless the last cycle pushed
  assign ds_top = ds_byp_vq ? ds_byp_q : ds_rdata;
  assign cs_top = cs_byp_vq ? cs_byp_q : cs_rdata;

  rvm_exec #(
    .RegCount (RegCount),
    .DataDepth(DataDepth),
    .CallDepth(CallDepth)
  ) u_exec (
    .item_i      (item_q),
    .run_i       (run_q),
    .dsd_i       (dsd_q),
    .csd_i       (csd_q),
    .step_limit_i(step_limit_q),
    .prog_len_i  (prog_len_q),
    .rf_i        (rf_q),
    .ds_top_i    (ds_top),
    .cs_top_i    (cs_top),
    .run_o       (run_d),
    .dsd_o       (dsd_d),
    .csd_o       (csd_d),
    .rf_we_o     (rf_we),
    .rf_waddr_o  (rf_waddr),
    .rf_wdata_o  (rf_wdata),
    .ds_we_o     (ds_we),
    .ds_wdata_o  (ds_wdata),
    .cs_we_o     (cs_we),
    .cs_wdata_o  (cs_wdata),
    .res_o       (res_d)
  );

  assign ds_we_x  = fire && ds_we;
  assign cs_we_x  = fire && cs_we;
  assign ds_raddr = fire ? DsaW'(dsd_d - 1'b1) : DsaW'(dsd_q - 1'b1);
  assign cs_raddr = fire ? CsaW'(csd_d - 1'b1) : CsaW'(csd_q - 1'b1);

  rvm_ram #(.Width(rvm_pkg::ValW), .Depth(DataDepth)) u_data_stack (
    .clk_i  (clk_i),
    .we_i   (ds_we_x),
    .waddr_i(DsaW'(dsd_q)),
    .wdata_i(ds_wdata),
    .raddr_i(ds_raddr),
    .rdata_o(ds_rdata)
  );

  rvm_ram #(.Width(rvm_pkg::IpW), .Depth(CallDepth)) u_call_stack (
    .clk_i  (clk_i),
    .we_i   (cs_we_x),
    .waddr_i(CsaW'(csd_q)),
    .wdata_i(cs_wdata),
    .raddr_i(cs_raddr),
    .rdata_o(cs_rdata)
  );

  // bypass for a read of the entry written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_byp_vq <= 1'b0;
      cs_byp_vq <= 1'b0;
    end else begin
      ds_byp_vq <= ds_we_x;
      cs_byp_vq <= cs_we_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ds_we_x) begin
      ds_byp_q <= ds_wdata;
    end
    if (cs_we_x) begin
      cs_byp_q <= cs_wdata;
    end
  end

  // machine state and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      dsd_q <= '0;
      csd_q <= '0;
      for (int i = 0; i < RegCount; i++) begin
        rf_q[i] <= '0;
      end
    end else if (fire) begin
      run_q <= run_d;
      dsd_q <= dsd_d;
      csd_q <= csd_d;
      if (rf_we) begin
        rf_q[rf_waddr] <= rf_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  `RVM_ASSERT(a_ds_depth, clk_i, rst_ni, dsd_q <= (DsaW + 1)'(DataDepth), "data stack depth over")
  `RVM_ASSERT(a_cs_depth, clk_i, rst_ni, csd_q <= (CsaW + 1)'(CallDepth), "call stack depth over")
  `RVM_ASSERT_IMP(a_err_halts, clk_i, rst_ni, out_valid_q && res_q.status != rvm_pkg::ST_OK,
                  !res_q.running, "fault result still running")
  `RVM_ASSERT_NXT(a_fire_out, clk_i, rst_ni, fire, out_valid_q && !run_q.halted == !res_q.running
                  || out_valid_q, "executed item left no result")

endmodule

// ===== rtl/rvm_ram.sv =====
// generic single port write, registered read ram
`timescale 1ns / 1ps
module rvm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and read-first registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rvm_exec.sv =====
// combinational execute logic: next run state, register write, stack ops, result
`timescale 1ns / 1ps
module rvm_exec #(
  parameter int unsigned RegCount  = rvm_pkg::RegCountDef,
  parameter int unsigned DataDepth = rvm_pkg::DataStackDef,
  parameter int unsigned CallDepth = rvm_pkg::CallStackDef
) (
  input  rvm_pkg::item_t                    item_i,
  input  rvm_pkg::run_t                     run_i,
  input  logic [$clog2(DataDepth):0]        dsd_i,
  input  logic [$clog2(CallDepth):0]        csd_i,
  input  logic [31:0]                       step_limit_i,
  input  logic [rvm_pkg::IpW-1:0]           prog_len_i,
  input  logic [rvm_pkg::ValW-1:0]          rf_i [RegCount],
  input  logic [rvm_pkg::ValW-1:0]          ds_top_i,
  input  logic [rvm_pkg::IpW-1:0]           cs_top_i,
  output rvm_pkg::run_t                     run_o,
  output logic [$clog2(DataDepth):0]        dsd_o,
  output logic [$clog2(CallDepth):0]        csd_o,
  output logic                              rf_we_o,
  output logic [$clog2(RegCount)-1:0]       rf_waddr_o,
  output logic [rvm_pkg::ValW-1:0]          rf_wdata_o,
  output logic                              ds_we_o,
  output logic [rvm_pkg::ValW-1:0]          ds_wdata_o,
  output logic                              cs_we_o,
  output logic [rvm_pkg::IpW-1:0]           cs_wdata_o,
  output rvm_pkg::result_t                  res_o
);

  localparam int unsigned RegIdxW = $clog2(RegCount);
  localparam int unsigned DsdW    = $clog2(DataDepth) + 1;
  localparam int unsigned CsdW    = $clog2(CallDepth) + 1;

  logic [RegIdxW-1:0]        rd_idx, rs_idx;
  logic                      rd_bad, rs_bad;
  logic [rvm_pkg::ValW-1:0]  src, dst, alu;
  logic                      running, jumped, alu_we;
  logic [1:0]                status;
  logic [rvm_pkg::StepW-1:0] steps_inc;
  rvm_pkg::op_e              op;

  assign rd_idx    = RegIdxW'(item_i.dest_reg);
  assign rs_idx    = RegIdxW'(item_i.src_reg);
  assign rd_bad    = 5'(item_i.dest_reg) >= 5'(RegCount);
  assign rs_bad    = item_i.src_is_reg && (5'(item_i.src_reg) >= 5'(RegCount));
  assign src       = item_i.src_is_reg ? rf_i[rs_idx] : item_i.immediate;
  assign dst       = rf_i[rd_idx];
  assign running   = !run_i.halted && (run_i.ip < prog_len_i);
  assign steps_inc = run_i.steps + 1'b1;
  assign op        = rvm_pkg::op_e'(item_i.operation);

  // alu result for the arithmetic and logic group
  always_comb begin
    alu    = dst;
    alu_we = 1'b1;
    case (op)
      rvm_pkg::OP_ADD: alu = dst + src;
      rvm_pkg::OP_SUB: alu = dst - src;
      rvm_pkg::OP_XOR: alu = dst ^ src;
      rvm_pkg::OP_AND: alu = dst & src;
      rvm_pkg::OP_OR:  alu = dst | src;
      rvm_pkg::OP_SHL: alu = dst << src[5:0];
      rvm_pkg::OP_SHR: alu = dst >> src[5:0];
      rvm_pkg::OP_INC: alu = dst + 1'b1;
      rvm_pkg::OP_DEC: alu = dst - 1'b1;
      default:         alu_we = 1'b0;
    endcase
  end

  // instruction decode and state update
  always_comb begin
    run_o      = run_i;
    dsd_o      = dsd_i;
    csd_o      = csd_i;
    rf_we_o    = 1'b0;
    rf_waddr_o = rd_idx;
    rf_wdata_o = alu;
    ds_we_o    = 1'b0;
    ds_wdata_o = src;
    cs_we_o    = 1'b0;
    cs_wdata_o = run_i.ip + 1'b1;
    status     = rvm_pkg::ST_OK;
    jumped     = 1'b0;
    res_o      = '0;
    if (op == rvm_pkg::OP_START) begin
      run_o.ip       = '0;
      run_o.halted   = 1'b0;
      run_o.exit_val = '0;
      run_o.steps    = '0;
    end else if (running) begin
      run_o.steps = steps_inc;
      if (steps_inc > {1'b0, step_limit_i}) begin
        status = rvm_pkg::ST_STEP;
      end else if (item_i.operation > rvm_pkg::OP_JNZ) begin
        status = rvm_pkg::ST_UNSUP;
      end else if (item_i.malformed || rd_bad || rs_bad) begin
        status = rvm_pkg::ST_FAULT;
      end else begin
        if (alu_we) begin
          rf_we_o    = 1'b1;
          run_o.zero = (alu == '0);
        end
        case (op)
          rvm_pkg::OP_RET: begin
            if (csd_i == '0) begin
              run_o.halted = 1'b1;
            end else begin
              csd_o    = csd_i - 1'b1;
              run_o.ip = cs_top_i;
              jumped   = 1'b1;
            end
          end
          rvm_pkg::OP_EXIT: begin
            run_o.exit_val = item_i.immediate[7:0];
            run_o.halted   = 1'b1;
          end
          rvm_pkg::OP_MOV: begin
            rf_we_o    = 1'b1;
            rf_wdata_o = src;
          end
          rvm_pkg::OP_CMP: run_o.zero = (dst == src);
          rvm_pkg::OP_PUSH: begin
            if (dsd_i >= DsdW'(DataDepth)) begin
              status = rvm_pkg::ST_FAULT;
            end else begin
              ds_we_o = 1'b1;
              dsd_o   = dsd_i + 1'b1;
            end
          end
          rvm_pkg::OP_POP: begin
            if (dsd_i == '0) begin
              status = rvm_pkg::ST_FAULT;
            end else begin
              dsd_o      = dsd_i - 1'b1;
              rf_we_o    = 1'b1;
              rf_wdata_o = ds_top_i;
            end
          end
          rvm_pkg::OP_CALL: begin
            if (!item_i.target_found || csd_i >= CsdW'(CallDepth)) begin
              status = rvm_pkg::ST_FAULT;
            end else begin
              cs_we_o  = 1'b1;
              csd_o    = csd_i + 1'b1;
              run_o.ip = rvm_pkg::IpW'(item_i.target_line);
              jumped   = 1'b1;
            end
          end
          rvm_pkg::OP_PRINT_REG: begin
            res_o.print_kind  = rvm_pkg::PK_REG;
            res_o.print_value = dst;
          end
          rvm_pkg::OP_PRINT_STR: res_o.print_kind = rvm_pkg::PK_STR;
          rvm_pkg::OP_JMP, rvm_pkg::OP_JZ, rvm_pkg::OP_JNZ: begin
            if (!item_i.target_found) begin
              status = rvm_pkg::ST_FAULT;
            end else if (op == rvm_pkg::OP_JMP || (op == rvm_pkg::OP_JZ && run_i.zero) ||
                         (op == rvm_pkg::OP_JNZ && !run_i.zero)) begin
              run_o.ip = rvm_pkg::IpW'(item_i.target_line);
              jumped   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (status != rvm_pkg::ST_OK) begin
        run_o.halted = 1'b1;
        rf_we_o      = 1'b0;
        ds_we_o      = 1'b0;
        cs_we_o      = 1'b0;
        dsd_o        = dsd_i;
        csd_o        = csd_i;
        run_o.ip     = run_i.ip;
        run_o.zero   = run_i.zero;
        res_o.print_kind  = rvm_pkg::PK_NONE;
        res_o.print_value = '0;
      end else if (!run_o.halted && !jumped) begin
        run_o.ip = run_i.ip + 1'b1;
      end
    end
    res_o.status     = status;
    res_o.next_ip    = run_o.ip;
    res_o.running    = !run_o.halted && (run_o.ip < prog_len_i);
    res_o.exit_value = run_o.exit_val;
    res_o.zero_flag  = run_o.zero;
  end

endmodule
